### rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared widths, register indexes and item types for the button debouncer.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int FIELD_W    = 4;
    localparam int CNT_W      = 8;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS   = 4'd0,
        REG_LONG_PRESS_TICKS = 4'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [CNT_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] long_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic press;
        logic release_ev;
        logic level;
        logic long_ev;
    } t_lane_ev;

    typedef struct packed {
        logic [FIELD_W-1:0] pressed_events;
        logic [FIELD_W-1:0] released_events;
        logic [FIELD_W-1:0] held_mask;
        logic [FIELD_W-1:0] long_press_events;
    } t_result;

endpackage

### rtl/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Per-button debouncer with press, release and long-press event reporting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one sample tick of raw
//   button levels per item. Output channel (o_out_valid / i_out_ready)
//   returns one item per input item: pressed, released and long-press event
//   masks plus the debounced level mask after that tick.
//   One lane per button updates its counters in the accepting cycle; the
//   result is registered in the output buffer. Throughput is one item per
//   cycle while o_in_ready is high.
//   A skid register behind the output register lets one more item in while
//   a result waits; with both full, o_in_ready drops until the receiver
//   takes an item.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
//   debounce_ticks (low 8 bits), index 1 long_press_ticks (low 16 bits),
//   other indexes are ignored. Write only while idle.
//   Reset (synchronous, active low) clears all counters and levels, empties
//   the output buffer and loads debounce 5, long press 1000.
// ----------------------------------------------------------------------------
module button_debounce_long_press #(
    parameter int BUTTONS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [bdlp_pkg::FIELD_W-1:0]        i_raw_buttons,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [bdlp_pkg::FIELD_W-1:0]        o_pressed_events,
    output logic [bdlp_pkg::FIELD_W-1:0]        o_released_events,
    output logic [bdlp_pkg::FIELD_W-1:0]        o_held_mask,
    output logic [bdlp_pkg::FIELD_W-1:0]        o_long_press_events
);
    import bdlp_pkg::*;

    localparam int LANES = (BUTTONS < FIELD_W) ? BUTTONS : FIELD_W;

    t_cfg     r_cfg;
    logic     accept;
    logic     space;
    t_lane_ev lane_ev [LANES];
    t_result  merged;
    t_result  out_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = space;
    assign accept      = i_in_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= CNT_W'(5);
            r_cfg.long_press_ticks <= HOLD_W'(1000);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE_TICKS:   r_cfg.debounce_ticks   <= i_cfg_data[CNT_W-1:0];
                REG_LONG_PRESS_TICKS: r_cfg.long_press_ticks <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        bdlp_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (accept),
            .i_sample  (i_raw_buttons[k]),
            .i_cfg     (r_cfg),
            .o_ev      (lane_ev[k])
        );
    end

    always_comb begin
        merged = '0;
        for (int k = 0; k < LANES; k++) begin
            merged.pressed_events[k]    = lane_ev[k].press;
            merged.released_events[k]   = lane_ev[k].release_ev;
            merged.held_mask[k]         = lane_ev[k].level;
            merged.long_press_events[k] = lane_ev[k].long_ev;
        end
    end

    bdlp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (merged),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_pressed_events    = out_data.pressed_events;
    assign o_released_events   = out_data.released_events;
    assign o_held_mask         = out_data.held_mask;
    assign o_long_press_events = out_data.long_press_events;

endmodule

### rtl/bdlp_lane.sv
// ----------------------------------------------------------------------------
// bdlp_lane
// One button: stable-sample counter, debounced level, hold counter and
// long-press flag, advanced once per accepted item.
// ----------------------------------------------------------------------------
module bdlp_lane (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic            i_sample,
    input  bdlp_pkg::t_cfg  i_cfg,
    output bdlp_pkg::t_lane_ev o_ev
);
    import bdlp_pkg::*;

    logic              r_prev;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_level;
    logic [HOLD_W-1:0] r_hold;
    logic              r_long;

    logic              n_prev;
    logic [CNT_W-1:0]  n_cnt;
    logic              n_level;
    logic [HOLD_W-1:0] n_hold;
    logic              n_long;

    logic              flip;
    logic [HOLD_W-1:0] hold_base;
    logic              long_base;
    logic              long_ev;

    always_comb begin
        n_prev = i_sample;
        if (i_sample == r_prev) begin
            n_cnt = (r_cnt < i_cfg.debounce_ticks) ? r_cnt + 1'b1 : r_cnt;
        end else begin
            n_cnt = '0;
        end

        flip      = (n_cnt >= i_cfg.debounce_ticks) && (i_sample != r_level);
        n_level   = flip ? i_sample : r_level;
        hold_base = flip ? '0 : r_hold;
        long_base = (flip && !i_sample) ? 1'b0 : r_long;

        long_ev = 1'b0;
        n_hold  = hold_base;
        n_long  = long_base;
        if (n_level) begin
            n_hold  = (hold_base < HOLD_MAX) ? hold_base + 1'b1 : hold_base;
            long_ev = (n_hold >= i_cfg.long_press_ticks) && !long_base;
            n_long  = long_base | long_ev;
        end

        o_ev.press      = flip && i_sample;
        o_ev.release_ev = flip && !i_sample;
        o_ev.level      = n_level;
        o_ev.long_ev    = long_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_cnt   <= '0;
            r_level <= 1'b0;
            r_hold  <= '0;
            r_long  <= 1'b0;
        end else if (i_advance) begin
            r_prev  <= n_prev;
            r_cnt   <= n_cnt;
            r_level <= n_level;
            r_hold  <= n_hold;
            r_long  <= n_long;
        end
    end

    a_no_press_and_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ev.press && o_ev.release_ev))
        else $error("lane reports press and release together");

    a_long_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_ev.long_ev) |=> (r_level && r_long))
        else $error("long-press event without held level");

    a_press_restarts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_ev.press) |=> (r_hold == HOLD_W'(1)))
        else $error("hold count not restarted on press");

endmodule

### rtl/bdlp_merge.sv
// ----------------------------------------------------------------------------
// bdlp_merge
// Holds the merged lane results as one item in an output register
// backed by a skid register.
// ----------------------------------------------------------------------------
module bdlp_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bdlp_pkg::t_result   i_data,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output bdlp_pkg::t_result   o_data
);
    import bdlp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    load_out;

    assign load_out = !r_out_valid || i_ready;
    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_out) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid item held while output register empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("item pushed into full buffer");

    a_push_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_out_valid) |=> r_out_valid)
        else $error("pushed item lost");

endmodule

### sim/button_debounce_long_press_tb.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb
// Self-checking testbench for the button debouncer. A clocked driver sends raw
// samples from a queue, a clocked monitor compares every output item against
// a cycle-free model of the debounce, hold and long-press counters. Phases
// step through several threshold settings, including zero and full-scale.
// ----------------------------------------------------------------------------
module button_debounce_long_press_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdlp_pkg::*;

    localparam int BUTTONS    = 4;
    localparam int STALL_AT   = 400;
    localparam int STALL_LEN  = 300;
    localparam int HOLD_ITEMS = 120;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [FIELD_W-1:0]    i_raw_buttons = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [FIELD_W-1:0]    o_pressed_events;
    logic [FIELD_W-1:0]    o_released_events;
    logic [FIELD_W-1:0]    o_held_mask;
    logic [FIELD_W-1:0]    o_long_press_events;

    button_debounce_long_press #(.BUTTONS(BUTTONS)) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_raw_buttons       (i_raw_buttons),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_pressed_events    (o_pressed_events),
        .o_released_events   (o_released_events),
        .o_held_mask         (o_held_mask),
        .o_long_press_events (o_long_press_events)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // model state
    logic [CNT_W-1:0]   deb_thresh = 8'd5;
    logic [HOLD_W-1:0]  long_thresh = 16'd1000;
    logic [FIELD_W-1:0] model_prev = '0;
    logic [FIELD_W-1:0] debounced = '0;
    logic [FIELD_W-1:0] long_seen = '0;
    logic [CNT_W-1:0]   stable_cnt [BUTTONS];
    logic [HOLD_W-1:0]  hold_cnt [BUTTONS];

    logic [FIELD_W-1:0] pending_samples [$];
    t_result            predicted_events [$];

    int  mismatches = 0;
    int  samples_taken = 0;
    bit  idle_en = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_off_left = 0;
    bit  hold_off_done = 1'b0;

    initial begin
        for (int b = 0; b < BUTTONS; b++) begin
            stable_cnt[b] = '0;
            hold_cnt[b] = '0;
        end
    end

    function automatic t_result debounce_tick(logic [FIELD_W-1:0] raw);
        t_result r;
        r = '0;
        for (int b = 0; b < BUTTONS; b++) begin
            if (raw[b] == model_prev[b]) begin
                if (stable_cnt[b] < deb_thresh) stable_cnt[b]++;
            end else begin
                stable_cnt[b] = '0;
            end
            if (stable_cnt[b] >= deb_thresh && raw[b] != debounced[b]) begin
                hold_cnt[b] = '0;
                debounced[b] = raw[b];
                if (raw[b]) begin
                    r.pressed_events[b] = 1'b1;
                end else begin
                    r.released_events[b] = 1'b1;
                    long_seen[b] = 1'b0;
                end
            end
            if (debounced[b]) begin
                if (hold_cnt[b] != HOLD_MAX) hold_cnt[b]++;
                if (hold_cnt[b] >= long_thresh && !long_seen[b]) begin
                    r.long_press_events[b] = 1'b1;
                    long_seen[b] = 1'b1;
                end
            end
        end
        model_prev = raw;
        r.held_mask = debounced;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [FIELD_W-1:0] exp_v,
                                   logic [FIELD_W-1:0] got_v);
        $display("mismatch at %0t: %s expected %h got %h", $realtime, field, exp_v, got_v);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_events.push_back(debounce_tick(i_raw_buttons));
                samples_taken <= samples_taken + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (idle_en && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 5);
                    i_in_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_raw_buttons <= pending_samples.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off_left <= 0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
        end else if (!hold_off_done && samples_taken >= STALL_AT) begin
            hold_off_left <= STALL_LEN;
            hold_off_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_pressed_events, o_released_events, o_held_mask,
                        o_long_press_events};
                if (predicted_events.size() == 0) begin
                    report_mismatch("unexpected item, held_mask", '0, got.held_mask);
                end else begin
                    exp_r = predicted_events.pop_front();
                    if (got.pressed_events !== exp_r.pressed_events)
                        report_mismatch("pressed_events", exp_r.pressed_events,
                                        got.pressed_events);
                    if (got.released_events !== exp_r.released_events)
                        report_mismatch("released_events", exp_r.released_events,
                                        got.released_events);
                    if (got.held_mask !== exp_r.held_mask)
                        report_mismatch("held_mask", exp_r.held_mask, got.held_mask);
                    if (got.long_press_events !== exp_r.long_press_events)
                        report_mismatch("long_press_events", exp_r.long_press_events,
                                        got.long_press_events);
                end
            end
            if (hold_off_left > 0) begin
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 5);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_DEBOUNCE_TICKS:   deb_thresh = data[CNT_W-1:0];
            REG_LONG_PRESS_TICKS: long_thresh = data;
            default: ;
        endcase
    endtask

    // checked between edges so every clocked update has settled
    task automatic drain();
        do @(negedge i_clk);
        while (pending_samples.size() > 0 || i_in_valid || o_out_valid ||
               predicted_events.size() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    // per-button level runs with bounce glitches and some fully random noise
    task automatic queue_runs(int n, int min_run, int max_run, int bounce_pct,
                              int noise_pct);
        logic [FIELD_W-1:0] lvl;
        logic [FIELD_W-1:0] item;
        int                 run_left [BUTTONS];
        lvl = '0;
        for (int b = 0; b < BUTTONS; b++) run_left[b] = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1, 100) <= noise_pct) begin
                item = FIELD_W'($urandom_range(0, 15));
            end else begin
                for (int b = 0; b < BUTTONS; b++) begin
                    if (run_left[b] == 0) begin
                        if ($urandom_range(0, 3) != 0) lvl[b] = ~lvl[b];
                        run_left[b] = $urandom_range(min_run, max_run);
                    end
                    run_left[b]--;
                    item[b] = lvl[b];
                    if ($urandom_range(1, 100) <= bounce_pct) item[b] = ~item[b];
                end
            end
            pending_samples.push_back(item);
        end
    endtask

    initial begin
        logic [FIELD_W-1:0] seq_a [$];
        logic [FIELD_W-1:0] seq_b [$];
        seq_a = '{4'h0, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'h5, 4'hA,
                  4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0};
        seq_b = '{4'h0, 4'h1, 4'h3, 4'h2, 4'hF, 4'h0, 4'h8, 4'h8, 4'h0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds
        foreach (seq_a[i]) pending_samples.push_back(seq_a[i]);
        drain();

        // zero thresholds, high data bits dropped, unused indexes ignored
        write_reg(REG_DEBOUNCE_TICKS, 16'hFF00);
        write_reg(REG_LONG_PRESS_TICKS, 16'h0000);
        for (int k = int'(REG_LONG_PRESS_TICKS) + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
        foreach (seq_b[i]) pending_samples.push_back(seq_b[i]);
        drain();

        idle_en = 1'b1;
        write_reg(REG_DEBOUNCE_TICKS, 16'd1);
        write_reg(REG_LONG_PRESS_TICKS, 16'd1);
        queue_runs(250, 1, 6, 10, 10);
        drain();

        write_reg(REG_DEBOUNCE_TICKS, 16'd2);
        write_reg(REG_LONG_PRESS_TICKS, 16'd6);
        queue_runs(250, 1, 10, 8, 8);
        drain();

        write_reg(REG_DEBOUNCE_TICKS, 16'd3);
        write_reg(REG_LONG_PRESS_TICKS, 16'd40);
        queue_runs(300, 2, 60, 5, 5);
        drain();

        write_reg(REG_DEBOUNCE_TICKS, 16'd0);
        write_reg(REG_LONG_PRESS_TICKS, 16'd3);
        queue_runs(200, 1, 8, 10, 10);
        drain();

        write_reg(REG_DEBOUNCE_TICKS, 16'h0107);
        write_reg(REG_LONG_PRESS_TICKS, 16'd100);
        queue_runs(300, 5, 150, 3, 5);
        drain();

        write_reg(REG_DEBOUNCE_TICKS, 16'hFFFF);
        write_reg(REG_LONG_PRESS_TICKS, 16'd2);
        queue_runs(300, 200, 300, 1, 1);
        drain();

        // long hold on button 0, back to back
        idle_en = 1'b0;
        write_reg(REG_DEBOUNCE_TICKS, 16'd0);
        write_reg(REG_LONG_PRESS_TICKS, 16'd100);
        pending_samples.push_back(4'h0);
        for (int i = 0; i < HOLD_ITEMS; i++)
            pending_samples.push_back({3'($urandom_range(0, 7)), 1'b1});
        repeat (10) pending_samples.push_back(4'h0);
        drain();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
